// ===== rtl/lru_page_replacement_top_assert.svh =====
// assertion macros for the lru page replacement block
// both sample on clk and are disabled while arst_n is low
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// property that must hold in the same cycle
`define LPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

	localparam int FRAME_COUNT = 8;
	localparam int PAGE_BITS   = 16;
	localparam int FRAME_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int FILL_W      = $clog2(FRAME_COUNT + 1);
	localparam int LIMIT_W     = 4;
	localparam int FAULT_W     = 32;
	localparam int LIMIT_RESET = 3;

	// one position of the recency stack: frame id and the page it holds
	typedef struct packed {
		logic                 valid;
		logic [FRAME_W-1:0]   frame;
		logic [PAGE_BITS-1:0] page;
	} cell_t;

	typedef struct packed {
		logic                 load;
		logic [PAGE_BITS-1:0] probe;
	} cell_ctrl_t;

	typedef struct packed {
		logic                 load;
		logic                 full;
		logic [FILL_W-1:0]    filled;
		logic [PAGE_BITS-1:0] page;
	} chain_ctrl_t;

	typedef struct packed {
		logic                 hit;
		logic [FRAME_W-1:0]   slot;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
	} lookup_t;

endpackage

// ===== rtl/lpr_cell.sv =====
module lpr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lpr_pkg::cell_ctrl_t ctrl,
	input  lpr_pkg::cell_t      up,
	output lpr_pkg::cell_t      state,
	output logic               match
);
	import lpr_pkg::*;

	logic                 valid_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [PAGE_BITS-1:0] page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			frame_q <= up.frame;
			page_q  <= up.page;
		end
	end

	assign state.valid = valid_q;
	assign state.frame = frame_q;
	assign state.page  = page_q;
	assign match       = valid_q && (page_q == ctrl.probe);

endmodule

// ===== rtl/lpr_chain.sv =====
module lpr_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  lpr_pkg::chain_ctrl_t ctrl,
	output lpr_pkg::lookup_t     lk
);
	import lpr_pkg::*;

	cell_t                  cells [FRAME_COUNT];
	cell_t                  ups   [FRAME_COUNT];
	cell_ctrl_t             cctl  [FRAME_COUNT];
	logic [FRAME_COUNT-1:0] match;
	logic [FRAME_COUNT-1:0] shift;
	lookup_t                lk_c;

	always_comb begin
		logic                 acc;
		logic                 last;
		logic [FRAME_W-1:0]   hit_frame;
		logic [FRAME_W-1:0]   last_frame;
		logic [PAGE_BITS-1:0] last_page;
		acc        = 1'b0;
		hit_frame  = '0;
		last_frame = '0;
		last_page  = '0;
		shift      = '0;
		lk_c.hit   = |match;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			acc  = acc | match[i];
			last = (FILL_W'(i + 1) == ctrl.filled);
			if (match[i]) begin
				hit_frame = hit_frame | cells[i].frame;
			end
			if (last) begin
				last_frame = cells[i].frame;
				last_page  = cells[i].page;
			end
			// positions from the top down to the vacated one move down by one
			if (lk_c.hit) begin
				shift[i] = acc;
			end else if (!ctrl.full) begin
				shift[i] = (FILL_W'(i) <= ctrl.filled);
			end else begin
				shift[i] = (FILL_W'(i) < ctrl.filled);
			end
		end
		if (lk_c.hit) begin
			lk_c.slot = hit_frame;
		end else if (!ctrl.full) begin
			lk_c.slot = FRAME_W'(ctrl.filled);
		end else begin
			lk_c.slot = last_frame;
		end
		lk_c.ev_valid = !lk_c.hit && ctrl.full;
		lk_c.ev_page  = lk_c.ev_valid ? last_page : '0;
	end

	assign lk = lk_c;

	for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign ups[g].valid = 1'b1;
			assign ups[g].frame = lk_c.slot;
			assign ups[g].page  = ctrl.page;
		end else begin : g_link
			assign ups[g] = cells[g-1];
		end
		assign cctl[g].load  = ctrl.load && shift[g];
		assign cctl[g].probe = ctrl.page;

		lpr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cctl[g]),
			.up     (ups[g]),
			.state  (cells[g]),
			.match  (match[g])
		);
	end

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// lru page replacement: recency stack held as a row of shifting cells
// results are registered and appear in the cycle after a page word is accepted
// one word per cycle unless stalled; lookup, fill and eviction settle in one
// pass over the cell row, the register keeps input and output sides apart
// reset: all frames empty, fault count zero, frame limit 3; no clearing pass
`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lpr_pkg::PAGE_BITS-1:0] page_number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [lpr_pkg::FRAME_W-1:0]   frame_slot,
	output logic                        evicted_valid,
	output logic [lpr_pkg::PAGE_BITS-1:0] evicted_page,
	output logic [lpr_pkg::FAULT_W-1:0]   fault_total,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lpr_pkg::LIMIT_W-1:0]   frame_limit
);
	import lpr_pkg::*;

	logic [LIMIT_W-1:0]   limit_q;
	logic [FILL_W-1:0]    filled_q;
	logic [FAULT_W-1:0]   fault_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   slot_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [FILL_W-1:0]    lim_eff;
	logic                 accept;
	logic                 miss;
	chain_ctrl_t          cctl;
	lookup_t              lk;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign miss      = accept && !lk.hit;

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = FILL_W'(1);
		end else if (int'(limit_q) > FRAME_COUNT) begin
			lim_eff = FILL_W'(FRAME_COUNT);
		end else begin
			lim_eff = FILL_W'(limit_q);
		end
	end

	assign cctl.load   = accept;
	assign cctl.full   = (filled_q >= lim_eff);
	assign cctl.filled = filled_q;
	assign cctl.page   = page_number;

	lpr_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctl),
		.lk     (lk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_W'(LIMIT_RESET);
			filled_q    <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= frame_limit;
			end
			if (miss && !cctl.full) begin
				filled_q <= filled_q + FILL_W'(1);
			end
			// fault count sticks at all ones
			if (miss && (fault_q != '1)) begin
				fault_q <= fault_q + FAULT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= lk.hit;
			slot_q     <= lk.slot;
			ev_valid_q <= lk.ev_valid;
			ev_page_q  <= lk.ev_page;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	// the counter only moves with an accepted word, so it matches the held result
	assign fault_total   = fault_q;

	`LPR_ASSERT(a_filled_bound, int'(filled_q) <= FRAME_COUNT, "fill count beyond frame count")
	`LPR_ASSERT_NEXT(a_hit_keeps_fill, accept && lk.hit, $stable(filled_q), "fill count moved on a hit")
	`LPR_ASSERT_NEXT(a_fault_step, miss && (fault_q != '1), fault_q == $past(fault_q) + FAULT_W'(1), "fault count missed a step")
	`LPR_ASSERT(a_no_evict_zero, !(out_valid && !evicted_valid) || (evicted_page == '0), "evicted page not zero without eviction")

endmodule
